// ----- rtl/primitive_assembler_top_defines.svh -----
// Assertion shorthands for the primitive assembler.
// Both sample on clk and are disabled while arst_n is low.
`ifndef PRIMITIVE_ASSEMBLER_TOP_DEFINES_SVH
`define PRIMITIVE_ASSEMBLER_TOP_DEFINES_SVH

// Combinational or overlapping property.
`define PA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent in the next one.
`define PA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pa_pkg.sv -----
package pa_pkg;

	// Handle width of the ports; internal storage may be narrower.
	localparam int HANDLE_W = 16;

	// Jobs the queue between front and back can hold.
	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		MODE_POINTS         = 4'd0,
		MODE_LINES          = 4'd1,
		MODE_LINE_LOOP      = 4'd2,
		MODE_LINE_STRIP     = 4'd3,
		MODE_TRIANGLES      = 4'd4,
		MODE_TRIANGLE_STRIP = 4'd5,
		MODE_TRIANGLE_FAN   = 4'd6,
		MODE_QUADS          = 4'd7,
		MODE_QUAD_STRIP     = 4'd8,
		MODE_POLYGON        = 4'd9
	} mode_t;

	localparam logic [1:0] CNT_POINT = 2'd1;
	localparam logic [1:0] CNT_LINE  = 2'd2;
	localparam logic [1:0] CNT_TRI   = 2'd3;

	typedef struct packed {
		logic [3:0] prim_mode;
		logic       loop_continue;
		logic       loop_end;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          vertex_count;
		logic [HANDLE_W-1:0] vert_a;
		logic [HANDLE_W-1:0] vert_b;
		logic [HANDLE_W-1:0] vert_c;
	} prim_t;

	// One accepted vertex worth of primitives: one or two.
	typedef struct packed {
		logic  two;
		prim_t prim0;
		prim_t prim1;
	} job_t;

endpackage

// ----- rtl/pa_front.sv -----
module pa_front import pa_pkg::*; #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                accept,
	input  logic [HANDLE_W-1:0] vertex_handle,
	input  logic                batch_last,
	output logic                job_valid,
	output job_t                job
);

	localparam int SB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	logic [SB-1:0] first_q;
	logic [SB-1:0] prev_q [3];
	logic [1:0]    seen_q;
	logic [1:0]    ph4_q;
	logic [1:0]    ph3_q;

	logic [SB-1:0]       cur_n;
	logic [SB-1:0]       first_n;
	logic [HANDLE_W-1:0] cur, first, p1, p2, p3;
	logic                odd;
	logic                edge_ok, close_ok;

	assign cur_n   = vertex_handle[SB-1:0];
	assign first_n = (seen_q == 2'd0) ? cur_n : first_q;
	assign cur     = HANDLE_W'(cur_n);
	assign first   = HANDLE_W'(first_n);
	assign p1      = HANDLE_W'(prev_q[0]);
	assign p2      = HANDLE_W'(prev_q[1]);
	assign p3      = HANDLE_W'(prev_q[2]);
	assign odd     = ph4_q[0];

	// line loop: regular edge unless it is the skipped first edge
	assign edge_ok  = cfg.loop_continue ? (seen_q >= 2'd2) : (seen_q >= 2'd1);
	assign close_ok = batch_last && cfg.loop_end;

	always_comb begin
		job_valid = 1'b0;
		job       = '0;
		case (cfg.prim_mode)
			MODE_POINTS: begin
				job_valid = 1'b1;
				job.prim0 = '{CNT_POINT, cur, '0, '0};
			end
			MODE_LINES: begin
				job_valid = odd;
				job.prim0 = '{CNT_LINE, cur, p1, '0};
			end
			MODE_LINE_LOOP: begin
				job_valid = edge_ok || close_ok;
				job.two   = edge_ok && close_ok;
				if (edge_ok) begin
					job.prim0 = '{CNT_LINE, cur, p1, '0};
				end else begin
					job.prim0 = '{CNT_LINE, first, cur, '0};
				end
				job.prim1 = '{CNT_LINE, first, cur, '0};
			end
			MODE_LINE_STRIP: begin
				job_valid = (seen_q >= 2'd1);
				job.prim0 = '{CNT_LINE, cur, p1, '0};
			end
			MODE_TRIANGLES: begin
				job_valid = (ph3_q == 2'd2);
				job.prim0 = '{CNT_TRI, cur, p2, p1};
			end
			MODE_TRIANGLE_STRIP: begin
				job_valid = (seen_q >= 2'd2);
				if (odd) begin
					job.prim0 = '{CNT_TRI, cur, p1, p2};
				end else begin
					job.prim0 = '{CNT_TRI, cur, p2, p1};
				end
			end
			MODE_TRIANGLE_FAN: begin
				job_valid = (seen_q >= 2'd2);
				job.prim0 = '{CNT_TRI, cur, first, p1};
			end
			MODE_QUADS: begin
				job_valid = (ph4_q == 2'd3);
				job.two   = 1'b1;
				job.prim0 = '{CNT_TRI, cur, p3, p2};
				job.prim1 = '{CNT_TRI, cur, p2, p1};
			end
			MODE_QUAD_STRIP: begin
				job_valid = (seen_q == 2'd3) && odd;
				job.two   = 1'b1;
				job.prim0 = '{CNT_TRI, cur, p3, p2};
				job.prim1 = '{CNT_TRI, cur, p1, p3};
			end
			MODE_POLYGON: begin
				job_valid = (seen_q >= 2'd2);
				job.prim0 = '{CNT_TRI, first, p1, cur};
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			prev_q  <= '{default: '0};
			seen_q  <= '0;
			ph4_q   <= '0;
			ph3_q   <= '0;
		end else if (accept) begin
			first_q   <= first_n;
			prev_q[2] <= prev_q[1];
			prev_q[1] <= prev_q[0];
			prev_q[0] <= cur_n;
			if (batch_last) begin
				seen_q <= '0;
				ph4_q  <= '0;
				ph3_q  <= '0;
			end else begin
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
				ph4_q <= ph4_q + 2'd1;
				ph3_q <= (ph3_q >= 2'd2) ? 2'd0 : ph3_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/pa_queue.sv -----
module pa_queue import pa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output job_t rd_job,
	output logic [$clog2(QDEPTH+1)-1:0] count
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	job_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/pa_back.sv -----
module pa_back import pa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  head_valid,
	input  job_t  head_job,
	output logic  head_pop,
	output logic  out_valid,
	output prim_t out_prim,
	output logic  out_last,
	input  logic  out_pop
);

	logic  sel_q;
	logic  valid_q;
	prim_t prim_q;
	logic  last_q;

	logic  taken, load, is_last;
	prim_t prim;

	assign taken    = out_pop && valid_q;
	assign load     = head_valid && (!valid_q || taken);
	assign is_last  = !head_job.two || sel_q;
	assign prim     = sel_q ? head_job.prim1 : head_job.prim0;
	assign head_pop = load && is_last;

	assign out_valid = valid_q;
	assign out_prim  = prim_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			prim_q <= prim;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !is_last;
			end else if (taken) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/primitive_assembler_top.sv -----
// Primitive assembler: takes processed vertex handles in batch order (batch_last on the
// final one) and emits the points, lines or triangles they complete, for all ten GL
// primitive modes selected by prim_mode. Rate: the input side takes one vertex per
// cycle while full is low; the single result register delivers one primitive per
// cycle while empty or popped, so a vertex completing two primitives (quads, quad
// strips, a line loop's closing edge) delivers them in turn. Throughput is set by the
// back end's one-primitive-per-cycle output register; a two-job queue between the
// vertex tracker and the output sequencer lets either side stall alone. Configuration
// (APB, byte addresses 0, 4, 8) must only be written while the block is idle.
`include "primitive_assembler_top_defines.svh"

module primitive_assembler_top import pa_pkg::*; #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// vertex side
	input  logic                push,
	output logic                full,
	input  logic [HANDLE_W-1:0] vertex_handle,
	input  logic                batch_last,
	// primitive side
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          vertex_count,
	output logic [HANDLE_W-1:0] vert_a,
	output logic [HANDLE_W-1:0] vert_b,
	output logic [HANDLE_W-1:0] vert_c,
	output logic                run_last,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// register word indexes
	localparam logic [1:0] REG_PRIM_MODE     = 2'd0;
	localparam logic [1:0] REG_LOOP_CONTINUE = 2'd1;
	localparam logic [1:0] REG_LOOP_END      = 2'd2;

	cfg_t  cfg_q;
	logic  cfg_wr;

	logic  in_accept;
	logic  job_valid;
	job_t  job;
	logic  q_full, q_valid, q_pop;
	job_t  q_job;
	logic [$clog2(QDEPTH+1)-1:0] q_count;
	logic  out_valid;
	prim_t out_prim;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prim_mode     <= 4'd0;
			cfg_q.loop_continue <= 1'b0;
			cfg_q.loop_end      <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PRIM_MODE:     cfg_q.prim_mode     <= pwdata[3:0];
				REG_LOOP_CONTINUE: cfg_q.loop_continue <= pwdata[0];
				REG_LOOP_END:      cfg_q.loop_end      <= pwdata[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PRIM_MODE:     prdata = {28'd0, cfg_q.prim_mode};
			REG_LOOP_CONTINUE: prdata = {31'd0, cfg_q.loop_continue};
			REG_LOOP_END:      prdata = {31'd0, cfg_q.loop_end};
			default:           prdata = 32'd0;
		endcase
	end

	// ---- front: vertex tracking and classification ----
	// every accepted vertex updates the counters (batch_last clears them); only vertices that
	// complete something become a queue job
	assign full      = q_full;
	assign in_accept = push && !q_full;

	pa_front #(
		.HANDLE_BITS(HANDLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (in_accept),
		.vertex_handle(vertex_handle),
		.batch_last   (batch_last),
		.job_valid    (job_valid),
		.job          (job)
	);

	pa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept && job_valid),
		.wr_job  (job),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_job  (q_job),
		.count   (q_count)
	);

	// ---- back: one primitive per cycle into the result register while it is empty or popped ----
	pa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head_job  (q_job),
		.head_pop  (q_pop),
		.out_valid (out_valid),
		.out_prim  (out_prim),
		.out_last  (run_last),
		.out_pop   (pop)
	);

	assign empty        = !out_valid;
	assign vertex_count = out_prim.vertex_count;
	assign vert_a       = out_prim.vert_a;
	assign vert_b       = out_prim.vert_b;
	assign vert_c       = out_prim.vert_c;

	// ---- checks ----
	`PA_ASSERT(a_q_bound, (q_count <= ($clog2(QDEPTH+1))'(QDEPTH)), "job queue overflow")
	`PA_ASSERT_NEXT(a_fill, q_valid && (empty || pop), !empty, "result register not refilled")
	`PA_ASSERT(a_cnt_ok, (!empty |-> vertex_count != 2'd0), "result without vertex count")
	`PA_ASSERT_NEXT(a_pair, q_valid && q_job.two && !q_pop && (empty || pop),
		q_valid && !run_last, "second primitive of a pair lost")

endmodule
